>>> rtl/double_to_custom_float_unit_macros.svh
// Assertion macros for the double_to_custom_float_unit checker.
// Included by the checker file only.
`ifndef DOUBLE_TO_CUSTOM_FLOAT_UNIT_MACROS_SVH
`define DOUBLE_TO_CUSTOM_FLOAT_UNIT_MACROS_SVH
// Clocked assertion, disabled while reset is asserted.
`define D2CF_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked assertion that also holds during reset.
`define D2CF_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`endif

>>> rtl/d2cf_pkg.sv
// Package for the binary64 to custom float converter.
// Holds field widths, register indexes and rounding mode codes.
package d2cf_pkg;
    localparam int SrcW = 64;
    localparam int OutW = 32;
    localparam int CfgIdxW = 2;
    localparam int CfgDataW = 5;

    typedef enum logic [CfgIdxW-1:0] {
        REG_EXP_BITS  = 2'd0,
        REG_FRAC_BITS = 2'd1,
        REG_ROUND     = 2'd2,
        REG_NONE      = 2'd3
    } t_reg_idx;

    localparam logic [2:0] RM_NEAR_EVEN = 3'd0;
    localparam logic [2:0] RM_NEAR_AWAY = 3'd1;
    localparam logic [2:0] RM_TRUNC     = 3'd2;
    localparam logic [2:0] RM_UP        = 3'd3;
    localparam logic [2:0] RM_DOWN      = 3'd4;

    // Saturated format settings handed to the datapath.
    typedef struct packed {
        logic [3:0] exp_bits;
        logic [4:0] frac_bits;
        logic [2:0] round_mode;
    } t_fmt;
endpackage

>>> rtl/d2cf_if.sv
// Valid/ready stream interfaces for the converter channels.
// Depends on d2cf_pkg.
interface d2cf_src_if;
    logic                       valid;
    logic                       ready;
    logic [d2cf_pkg::SrcW-1:0]  source_bits;
    modport source (output valid, output source_bits, input ready);
    modport sink (input valid, input source_bits, output ready);
endinterface

interface d2cf_res_if;
    logic                       valid;
    logic                       ready;
    logic [d2cf_pkg::OutW-1:0]  packed_value;
    modport source (output valid, output packed_value, input ready);
    modport sink (input valid, input packed_value, output ready);
endinterface

interface d2cf_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [d2cf_pkg::CfgIdxW-1:0]   index;
    logic [d2cf_pkg::CfgDataW-1:0]  data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/d2cf_cfg_regs.sv
// Configuration registers with width saturation.
// Depends on d2cf_pkg and d2cf_cfg_if.
module d2cf_cfg_regs (
    input  logic           i_clk,
    input  logic           i_rst_n,
    d2cf_cfg_if.sink       cfg,
    output d2cf_pkg::t_fmt o_fmt
);
    import d2cf_pkg::*;

    logic [3:0] r_exp;
    logic [4:0] r_frac;
    logic [2:0] r_rm;
    logic [3:0] e_sat;
    logic [4:0] m_max;

    assign cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp  <= 4'd8;
            r_frac <= 5'd23;
            r_rm   <= RM_NEAR_EVEN;
        end else if (cfg.valid) begin
            unique case (t_reg_idx'(cfg.index))
                REG_EXP_BITS:  r_exp  <= cfg.data[3:0];
                REG_FRAC_BITS: r_frac <= cfg.data;
                REG_ROUND:     r_rm   <= cfg.data[2:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        e_sat = (r_exp < 4'd2) ? 4'd2 : ((r_exp > 4'd11) ? 4'd11 : r_exp);
        m_max = 5'd31 - {1'b0, e_sat};
        o_fmt.exp_bits   = e_sat;
        o_fmt.frac_bits  = (r_frac < 5'd1) ? 5'd1 : ((r_frac > m_max) ? m_max : r_frac);
        o_fmt.round_mode = r_rm;
    end
endmodule

>>> rtl/d2cf_convert.sv
// Combinational binary64 to custom float conversion with rounding.
// Depends on d2cf_pkg.
module d2cf_convert (
    input  logic [63:0]    i_src,
    input  d2cf_pkg::t_fmt i_fmt,
    output logic [31:0]    o_res
);
    import d2cf_pkg::*;

    logic        sign;
    logic [10:0] dexp;
    logic [51:0] dfrac;
    logic [11:0] top;
    logic signed [13:0] biased;
    logic [5:0]  s;
    logic [51:0] mant_w;
    logic [51:0] rem_mask;
    logic [51:0] rem;
    logic [51:0] half;
    logic [29:0] mant;
    logic [30:0] mant_inc;
    logic        up;
    logic        carry;
    logic signed [13:0] biased_f;
    logic [31:0] inf_w;

    always_comb begin
        sign  = i_src[63];
        dexp  = i_src[62:52];
        dfrac = i_src[51:0];
        top   = (12'd1 << i_fmt.exp_bits) - 12'd1;
        biased = $signed({3'b0, dexp}) - 14'sd1023
               + $signed({2'b0, (12'd1 << (i_fmt.exp_bits - 4'd1)) - 12'd1});
        s        = 6'd52 - {1'b0, i_fmt.frac_bits};
        mant_w   = dfrac >> s;
        mant     = mant_w[29:0];
        rem_mask = (52'd1 << s) - 52'd1;
        rem      = dfrac & rem_mask;
        half     = 52'd1 << (s - 6'd1);
        unique case (i_fmt.round_mode)
            RM_NEAR_EVEN: up = (rem > half) || ((rem == half) && mant[0]);
            RM_NEAR_AWAY: up = (rem >= half);
            RM_UP:        up = !sign && (rem != 52'd0);
            RM_DOWN:      up = sign && (rem != 52'd0);
            default:      up = 1'b0;
        endcase
        mant_inc = {1'b0, mant} + {30'd0, up};
        carry    = mant_inc[i_fmt.frac_bits];
        biased_f = carry ? biased + 14'sd1 : biased;
        inf_w    = {sign, 31'd0} | (32'({20'd0, top}) << i_fmt.frac_bits);
        if (dexp == 11'd0 || biased <= 14'sd0) begin
            o_res = 32'd0;
        end else if (dexp == 11'h7FF || biased_f >= $signed({2'b0, top})) begin
            o_res = inf_w;
        end else begin
            o_res = {sign, 31'd0}
                  | (32'(biased_f[11:0]) << i_fmt.frac_bits)
                  | (carry ? 32'd0 : {2'b0, mant_inc[29:0]});
        end
    end
endmodule

>>> rtl/double_to_custom_float_unit.sv
// Binary64 to configurable float converter, top level.
// Structure: input register, then combinational conversion, then result register.
// Throughput: one transaction per cycle; a full pipe stalls only when the result is not taken.
// Reset: synchronous active-low; empties both stages and restores 8/23/nearest-even format.
module double_to_custom_float_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    d2cf_src_if.sink  src,
    d2cf_res_if.source res,
    d2cf_cfg_if.sink  cfg
);
    import d2cf_pkg::*;

    t_fmt        fmt;
    logic        r_in_vld;
    logic [63:0] r_in;
    logic        r_out_vld;
    logic [31:0] r_out;
    logic [31:0] n_out;
    logic        adv_out;
    logic        adv_in;

    d2cf_cfg_regs u_cfg (.i_clk, .i_rst_n, .cfg, .o_fmt(fmt));
    d2cf_convert u_conv (.i_src(r_in), .i_fmt(fmt), .o_res(n_out));

    assign adv_out   = !r_out_vld || res.ready;
    assign adv_in    = !r_in_vld || adv_out;
    assign src.ready = adv_in;
    assign res.valid = r_out_vld;
    assign res.packed_value = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (adv_in) r_in_vld <= src.valid;
            if (adv_out) r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv_in && src.valid) r_in <= src.source_bits;
        if (adv_out && r_in_vld) r_out <= n_out;
    end
endmodule

>>> rtl/d2cf_checker.sv
// Port-level assertions for double_to_custom_float_unit, bound to the top.
// Depends on double_to_custom_float_unit_macros.svh.
`include "double_to_custom_float_unit_macros.svh"
module d2cf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_src_valid,
    input logic        i_src_ready,
    input logic        i_res_valid,
    input logic        i_res_ready,
    input logic [31:0] i_res_data
);
    `D2CF_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !i_res_valid,
        "result valid after reset")
    `D2CF_ASSERT(a_hold, i_clk, i_rst_n,
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res_data),
        "stalled result changed")
    `D2CF_ASSERT(a_ready_free, i_clk, i_rst_n, !i_res_valid |-> i_src_ready,
        "input blocked with empty output")
    `D2CF_ASSERT(a_latency, i_clk, i_rst_n,
        i_src_valid && i_src_ready ##1 i_res_ready |=> i_res_valid,
        "result missing after two cycles")
endmodule

bind double_to_custom_float_unit d2cf_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_src_valid(src.valid), .i_src_ready(src.ready),
    .i_res_valid(res.valid), .i_res_ready(res.ready), .i_res_data(res.packed_value)
);

>>> sim/double_to_custom_float_unit_checker.sv
// Scoreboard for double_to_custom_float_unit: tracks format registers, predicts
// each packed result from the source transaction and compares in order.
// Depends on d2cf_pkg and the channel interfaces in rtl/d2cf_if.sv.
module double_to_custom_float_unit_checker
    import d2cf_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    d2cf_src_if   src,
    d2cf_res_if   res,
    d2cf_cfg_if   cfg,
    output int    o_pending,
    output int    o_errors
);
    logic [3:0]  exp_width;
    logic [4:0]  frac_width;
    logic [2:0]  rounding;
    logic [31:0] packed_queue[$];

    task automatic report_mismatch(input string what);
        $display("[%0t] MISMATCH: %s", $realtime, what);
        o_errors++;
    endtask

    function automatic logic [31:0] infinity_word(logic sign, int e, int m);
        return {sign, 31'd0} | (((32'd1 << e) - 32'd1) << m);
    endfunction

    function automatic logic [31:0] predict_packed(logic [63:0] x);
        int          e;
        int          m;
        int          s;
        int          top;
        int          biased;
        logic        sign;
        logic [10:0] dexp;
        logic [51:0] dfrac;
        logic [31:0] mant;
        logic [63:0] rem;
        logic [63:0] half;
        bit          up;
        e = exp_width;
        m = frac_width;
        if (e < 2) e = 2;
        if (e > 11) e = 11;
        if (m < 1) m = 1;
        if (m > 31 - e) m = 31 - e;
        sign = x[63];
        dexp = x[62:52];
        dfrac = x[51:0];
        if (dexp == 11'd0) return 32'd0;
        if (dexp == 11'h7FF) return infinity_word(sign, e, m);
        top = (1 << e) - 1;
        biased = int'(dexp) - 1023 + ((1 << (e - 1)) - 1);
        if (biased <= 0) return 32'd0;
        if (biased >= top) return infinity_word(sign, e, m);
        s = 52 - m;
        mant = 32'({12'd0, dfrac} >> s);
        rem = {12'd0, dfrac} & ((64'd1 << s) - 64'd1);
        half = 64'd1 << (s - 1);
        case (rounding)
            RM_NEAR_EVEN: up = (rem > half) || (rem == half && mant[0]);
            RM_NEAR_AWAY: up = (rem >= half);
            RM_UP:        up = !sign && rem != 0;
            RM_DOWN:      up = sign && rem != 0;
            default:      up = 1'b0;
        endcase
        if (up) mant++;
        if (mant >= (32'd1 << m)) begin
            mant = 32'd0;
            biased++;
            if (biased >= top) return infinity_word(sign, e, m);
        end
        return {sign, 31'd0} | (32'(biased) << m) | mant;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            exp_width <= 4'd8;
            frac_width <= 5'd23;
            rounding <= RM_NEAR_EVEN;
            packed_queue.delete();
            o_errors = 0;
        end else begin
            if (cfg.valid && cfg.ready) begin
                case (cfg.index)
                    REG_EXP_BITS:  exp_width <= cfg.data[3:0];
                    REG_FRAC_BITS: frac_width <= cfg.data;
                    REG_ROUND:     rounding <= cfg.data[2:0];
                    default: ;
                endcase
            end
            if (src.valid && src.ready)
                packed_queue.push_back(predict_packed(src.source_bits));
            if (res.valid && res.ready) begin
                if (packed_queue.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %h", res.packed_value));
                end else begin
                    logic [31:0] want;
                    want = packed_queue.pop_front();
                    if (res.packed_value !== want)
                        report_mismatch($sformatf("packed_value %h, want %h",
                                                  res.packed_value, want));
                end
            end
        end
        o_pending = packed_queue.size();
    end
endmodule

>>> sim/double_to_custom_float_unit_tb.sv
// Top of the double_to_custom_float_unit testbench: clock, reset, format phases,
// directed and random binary64 operands, result back-pressure and verdict.
// Depends on d2cf_pkg, rtl/d2cf_if.sv and double_to_custom_float_unit_checker.
module double_to_custom_float_unit_tb;
    import d2cf_pkg::*;

    logic i_clk;
    logic i_rst_n;
    int   pending;
    int   errors;
    bit   calm;
    int   exp_now;
    int   frac_now;
    int   ready_left = 0;

    d2cf_src_if src ();
    d2cf_res_if res ();
    d2cf_cfg_if cfg ();

    double_to_custom_float_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .src(src), .res(res), .cfg(cfg)
    );

    double_to_custom_float_unit_checker checker_inst (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .src(src), .res(res), .cfg(cfg),
        .o_pending(pending), .o_errors(errors)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin
        #20000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Result back-pressure in bursts; once calm, every new burst is ready.
    always @(posedge i_clk) begin
        if (ready_left > 0) begin
            ready_left <= ready_left - 1;
        end else if (calm || $urandom_range(2) != 0) begin
            res.ready <= 1'b1;
            ready_left <= $urandom_range(20, 1);
        end else begin
            res.ready <= 1'b0;
            ready_left <= $urandom_range(7, 1);
        end
    end

    // Drop the source, then hold until every expected result has come.
    task automatic drain_results();
        src.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [4:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= value;
        do @(posedge i_clk); while (!(cfg.valid && cfg.ready));
    endtask

    task automatic set_format(int e, int m, logic [2:0] mode);
        drain_results();
        write_reg(REG_EXP_BITS, 5'(e));
        write_reg(REG_FRAC_BITS, 5'(m));
        write_reg(REG_ROUND, {2'b00, mode});
        cfg.valid <= 1'b0;
        exp_now = e;
        frac_now = m;
    endtask

    task automatic send_operand(logic [63:0] x);
        src.valid <= 1'b1;
        src.source_bits <= x;
        do @(posedge i_clk); while (!(src.valid && src.ready));
        if (!calm && $urandom_range(3) == 0) begin
            src.valid <= 1'b0;
            repeat ($urandom_range(7, 1)) @(posedge i_clk);
        end
    endtask

    // Bias the exponent around the target range and the fraction toward ties and carries.
    function automatic logic [63:0] pick_operand();
        int          e;
        int          m;
        int          s;
        int          bias;
        int          dexp;
        logic [51:0] frac;
        e = exp_now < 2 ? 2 : (exp_now > 11 ? 11 : exp_now);
        m = frac_now < 1 ? 1 : frac_now;
        if (m > 31 - e) m = 31 - e;
        s = 52 - m;
        bias = (1 << (e - 1)) - 1;
        frac = 52'({$urandom, $urandom});
        case ($urandom_range(9))
            0: return {$urandom, $urandom};
            1: dexp = $urandom_range(1) ? 0 : 2047;
            default: dexp = 1023 + $urandom_range(2 * bias + 6) - bias - 3;
        endcase
        if (dexp < 0) dexp = 0;
        if (dexp > 2047) dexp = 2047;
        case ($urandom_range(5))
            0: frac = (frac >> s << s) | (52'd1 << (s - 1));
            1: frac = frac | ((52'd1 << s) - 52'd1);
            2: frac = '1;
            3: frac = frac >> s << s;
            default: ;
        endcase
        return {1'($urandom), 11'(dexp), frac};
    endfunction

    initial begin
        logic [63:0] directed[$];
        int          formats[$][3];
        i_rst_n = 1'b0;
        calm = 1'b0;
        exp_now = 8;
        frac_now = 23;
        src.valid = 1'b0;
        src.source_bits = '0;
        cfg.valid = 1'b0;
        cfg.index = REG_EXP_BITS;
        cfg.data = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Zero, signed zero, subnormal, infinities, NaN, max finite, ones, ties,
        // carry into overflow, smallest normal in target, values below it.
        directed = '{64'h0, 64'h8000000000000000, 64'h000FFFFFFFFFFFFF,
                     64'h7FF0000000000000, 64'hFFF0000000000000, 64'h7FF8000000000001,
                     64'h7FEFFFFFFFFFFFFF, 64'h3FF0000000000000, 64'hBFF0000000000000,
                     64'h3FF0000010000000, 64'h3FF0000030000000, 64'hBFF0000010000000,
                     64'h47EFFFFFF0000000, 64'hC7EFFFFFFFFFFFFF, 64'h3810000000000000,
                     64'h380FFFFFFFFFFFFF, 64'h3FF0000010000001, 64'h3FF00000000000FF};
        for (int mode = 0; mode < 5; mode++) begin
            if (mode != 0) set_format(8, 23, 3'(mode));
            foreach (directed[i]) send_operand(directed[i]);
        end

        // Saturation extremes included: 0/0 and 15/31 clamp, 11/29 clamps the fraction.
        formats = '{'{8, 23, 0}, '{2, 1, 1}, '{11, 20, 3}, '{11, 29, 4}, '{0, 0, 0},
                    '{15, 31, 2}, '{5, 10, 7}, '{2, 29, 5}, '{4, 3, 6}, '{8, 23, 1}};
        foreach (formats[p]) begin
            for (int r = 0; r < 2; r++) begin
                set_format(formats[p][0], formats[p][1], 3'($urandom_range(7)));
                if (r == 0) set_format(formats[p][0], formats[p][1], 3'(formats[p][2]));
                if (p == formats.size() - 1 && r == 1) calm = 1'b1;
                repeat (60) send_operand(pick_operand());
            end
        end
        drain_results();
        write_reg(REG_NONE, 5'h1F);
        cfg.valid <= 1'b0;
        drain_results();
        repeat (10) @(posedge i_clk);
        if (errors == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

>>> sim.f
+incdir+rtl
rtl/d2cf_pkg.sv
rtl/d2cf_if.sv
rtl/d2cf_cfg_regs.sv
rtl/d2cf_convert.sv
rtl/double_to_custom_float_unit.sv
rtl/d2cf_checker.sv
sim/double_to_custom_float_unit_checker.sv
sim/double_to_custom_float_unit_tb.sv
